### rtl/core/bbn_pkg.sv
// Shared constants, codes and types of the 3x3 normalized box blur.
`default_nettype none
package bbn_pkg;

    // Line store geometry
    localparam int MAX_WIDTH  = 128;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field and register widths
    localparam int PIX_W     = 8;
    localparam int WCFG_W    = 8;
    localparam int HCFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 12;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [WCFG_W-1:0]    WIDTH_RESET      = 8'd100;
    localparam logic [HCFG_W-1:0]    HEIGHT_RESET     = 11'd100;

    // Input command codes
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Divisor codes for the in-frame cell count
    localparam logic [1:0] DIV_BY_9 = 2'd0;
    localparam logic [1:0] DIV_BY_6 = 2'd1;
    localparam logic [1:0] DIV_BY_4 = 2'd2;

    // Reciprocals, scaled by 2^RECIP_SHIFT and rounded up; exact for SUM_W-bit sums
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 14;
    localparam logic [RECIP_W-1:0] RECIP_9 = 14'd7282;
    localparam logic [RECIP_W-1:0] RECIP_6 = 14'd10923;

    // One transfer entering the line store read stage
    typedef struct packed {
        logic             valid;
        logic             drain;
        logic             fire;
        logic             rst_out;
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] addr;
    } t_req;

    // Line store write-back
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] recent;
    } t_store_wr;

    // Window sum on its way to the divider
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [1:0]       div;
        logic [SUM_W-1:0] sum;
    } t_mean_req;

endpackage
`default_nettype wire

### rtl/core/bbn_line_store.sv
// Two line stores with registered read and write-to-read forwarding.
`default_nettype none
module bbn_line_store
    import bbn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [COL_W-1:0] i_rd_addr,
    input  wire t_store_wr        i_wr,
    output logic      [PIX_W-1:0] o_rd_older,
    output logic      [PIX_W-1:0] o_rd_recent
);

    logic [PIX_W-1:0] r_older_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] r_recent_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_older;
    logic [PIX_W-1:0] r_rd_recent;
    logic             hit;

    assign hit = i_wr.en && (i_wr.addr == i_rd_addr);

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_older_mem[i_wr.addr]  <= i_wr.older;
            r_recent_mem[i_wr.addr] <= i_wr.recent;
        end
    end

    // Read port; a same-edge write to the read entry is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_older  <= hit ? i_wr.older  : r_older_mem[i_rd_addr];
            r_rd_recent <= hit ? i_wr.recent : r_recent_mem[i_rd_addr];
        end
    end

    assign o_rd_older  = r_rd_older;
    assign o_rd_recent = r_rd_recent;

endmodule
`default_nettype wire

### rtl/core/bbn_window.sv
// Window registers, output position and masked 3x3 sum.
`default_nettype none
module bbn_window
    import bbn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_move,
    input  wire logic              i_restart,
    input  wire logic [WCFG_W-1:0] i_width,
    input  wire logic [HCFG_W-1:0] i_height,
    input  wire t_req              i_req,
    input  wire logic [PIX_W-1:0]  i_rd_older,
    input  wire logic [PIX_W-1:0]  i_rd_recent,
    output t_store_wr              o_wr,
    output t_mean_req              o_mean
);

    t_req             r_s1;
    t_mean_req        r_s2;
    logic [PIX_W-1:0] r_win [6];
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;

    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] n_out_col;
    logic [ROW_W-1:0] n_out_row;
    logic             top_in, bot_in, left_in, right_in;
    logic             rows3, cols3;
    logic [PIX_W-1:0] new_bot;
    logic [SUM_W-1:0] n_sum;
    logic [1:0]       n_div;
    logic             emit, step;

    assign step = i_move && r_s1.valid;
    assign emit = r_s1.valid && (r_s1.fire || r_s1.drain);

    // Position of this output and which window cells lie in the frame
    always_comb begin
        cur_col  = r_s1.rst_out ? '0 : r_out_col;
        cur_row  = r_s1.rst_out ? '0 : r_out_row;
        top_in   = (cur_row != '0);
        bot_in   = ({1'b0, cur_row} + HCFG_W'(1)) < i_height;
        left_in  = (cur_col != '0);
        right_in = ({1'b0, cur_col} + WCFG_W'(1)) < i_width;
        new_bot  = r_s1.drain ? '0 : r_s1.pix;
        rows3    = top_in && bot_in;
        cols3    = left_in && right_in;
        if (rows3 && cols3) begin
            n_div = DIV_BY_9;
        end else if (rows3 || cols3) begin
            n_div = DIV_BY_6;
        end else begin
            n_div = DIV_BY_4;
        end
    end

    // Masked sum: left = r_win[0..2], middle = r_win[3..5], right = new column
    always_comb begin
        n_sum = SUM_W'(r_win[4]);
        if (top_in)               n_sum = n_sum + SUM_W'(r_win[3]);
        if (bot_in)               n_sum = n_sum + SUM_W'(r_win[5]);
        if (left_in)              n_sum = n_sum + SUM_W'(r_win[1]);
        if (left_in && top_in)    n_sum = n_sum + SUM_W'(r_win[0]);
        if (left_in && bot_in)    n_sum = n_sum + SUM_W'(r_win[2]);
        if (right_in)             n_sum = n_sum + SUM_W'(i_rd_recent);
        if (right_in && top_in)   n_sum = n_sum + SUM_W'(i_rd_older);
        if (right_in && bot_in)   n_sum = n_sum + SUM_W'(new_bot);
    end

    // Next output position
    always_comb begin
        n_out_col = cur_col;
        n_out_row = cur_row;
        if (emit) begin
            if (!right_in) begin
                n_out_col = '0;
                n_out_row = bot_in ? cur_row + ROW_W'(1) : '0;
            end else begin
                n_out_col = cur_col + COL_W'(1);
            end
        end
    end

    // Write-back: the recent row moves to the older store
    always_comb begin
        o_wr.en     = step && !r_s1.drain;
        o_wr.addr   = r_s1.addr;
        o_wr.older  = i_rd_recent;
        o_wr.recent = r_s1.pix;
    end

    // Stage registers, sum payload and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_move) begin
                r_s1       <= i_req;
                r_s2.valid <= emit;
                r_s2.sum   <= n_sum;
                r_s2.div   <= n_div;
                r_s2.last  <= !bot_in && !right_in;
            end
            if (step) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= i_rd_older;
                r_win[4] <= i_rd_recent;
                r_win[5] <= new_bot;
            end
            if (i_restart) begin
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (step) begin
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
        end
    end

    assign o_mean = r_s2;

endmodule
`default_nettype wire

### rtl/core/bbn_mean.sv
// Divides the window sum by its cell count into the output register.
`default_nettype none
module bbn_mean
    import bbn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_move,
    input  wire t_mean_req        i_mean,
    output logic                  o_valid,
    output logic      [PIX_W-1:0] o_pixel,
    output logic                  o_last
);

    localparam int PROD_W = SUM_W + RECIP_W;

    logic               r_valid;
    logic [PIX_W-1:0]   r_pixel;
    logic               r_last;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    logic [PIX_W-1:0]   n_pixel;

    // Reciprocal multiply for 9 and 6, shift for 4
    always_comb begin
        recip = (i_mean.div == DIV_BY_9) ? RECIP_9 : RECIP_6;
        prod  = PROD_W'(i_mean.sum) * PROD_W'(recip);
        unique case (i_mean.div)
            DIV_BY_9, DIV_BY_6: n_pixel = prod[RECIP_SHIFT +: PIX_W];
            DIV_BY_4:           n_pixel = i_mean.sum[2 +: PIX_W];
            default:            n_pixel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_move) begin
            r_valid <= i_mean.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move) begin
            r_pixel <= n_pixel;
            r_last  <= i_mean.last;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

endmodule
`default_nettype wire

### rtl/core/box_blur_3x3_border_normalized_top.sv
// Top level of the streaming 3x3 normalized box blur.
//
// Slave stream: one transfer per command. tuser = cmd (0 push pixel,
// 1 drain one pending output), tdata = pixel_in. Master stream: tdata =
// blurred pixel, tlast marks the bottom-right pixel of a frame.
// Output k of a frame is produced by input k + width + 1; after the last
// pixel of a frame send width + 1 drain commands to flush the frame.
// Throughput is one transfer per cycle while the master takes results,
// set by the single read and write-back of the line stores per pixel.
// The three stages (store read, window sum, divide/output) advance
// together: when the output register holds a result that is not taken,
// s_tready drops and the pipeline holds.
// Configuration: index 0 frame width, index 1 frame height; a write also
// restarts the frame and must be made while the block is idle. Writes to
// other indexes are ignored.
// Reset clears positions and window and loads width = height = 100.
// The line stores are not cleared; no clearing pass is needed.
`default_nettype none
module box_blur_3x3_border_normalized_top
    import bbn_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [PIX_W-1:0]     s_tdata,   // [7:0] pixel_in
    input  wire logic                 s_tuser,   // [0] cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [PIX_W-1:0]     m_tdata,   // [7:0] pixel_out
    output logic                      m_tlast,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [HCFG_W-1:0]    i_cfg_data
);

    logic [WCFG_W-1:0] r_width_cfg;
    logic [HCFG_W-1:0] r_height_cfg;
    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [WCFG_W-1:0] r_pending;

    logic [WCFG_W-1:0] w_eff;
    logic [HCFG_W-1:0] h_eff;
    logic              move, accept, cfg_wr, restart;
    logic [COL_W-1:0]  ic;
    logic [ROW_W-1:0]  ir;
    logic [WCFG_W-1:0] w_plus1;
    logic [WCFG_W-1:0] drain_d;
    logic              drain_ok;
    logic [COL_W-1:0]  n_in_col;
    logic [ROW_W-1:0]  n_in_row;
    logic [WCFG_W-1:0] n_pending;
    t_req              req;
    t_store_wr         wr;
    t_mean_req         mean;
    logic [PIX_W-1:0]  rd_older, rd_recent;

    // Clamped frame size
    always_comb begin
        if (r_width_cfg < WCFG_W'(2)) begin
            w_eff = WCFG_W'(2);
        end else if (r_width_cfg > WCFG_W'(MAX_WIDTH)) begin
            w_eff = WCFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width_cfg;
        end
        if (r_height_cfg < HCFG_W'(2)) begin
            h_eff = HCFG_W'(2);
        end else if (r_height_cfg > HCFG_W'(MAX_HEIGHT)) begin
            h_eff = HCFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height_cfg;
        end
    end

    // Handshakes
    assign move        = !m_tvalid || m_tready;
    assign s_tready    = move;
    assign accept      = s_tvalid && move;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid &&
                         (i_cfg_addr == REG_FRAME_WIDTH || i_cfg_addr == REG_FRAME_HEIGHT);
    assign restart     = cfg_wr;

    // Input position, drain bookkeeping and the request to the store
    always_comb begin
        ic       = ({1'b0, r_in_col} < w_eff) ? r_in_col : '0;
        ir       = ({1'b0, r_in_row} < h_eff) ? r_in_row : '0;
        w_plus1  = w_eff + WCFG_W'(1);
        drain_d  = w_plus1 - r_pending;
        drain_ok = (r_pending != '0) && (r_pending <= w_plus1);

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_pending = r_pending;

        req.drain   = (s_tuser == CMD_DRAIN);
        req.pix     = s_tdata;
        req.fire    = 1'b0;
        req.rst_out = 1'b0;
        req.addr    = ic;
        req.valid   = 1'b0;

        if (s_tuser == CMD_PUSH) begin
            req.valid   = accept;
            req.rst_out = (r_pending != '0);
            req.fire    = (ir >= ROW_W'(2)) || (ir == ROW_W'(1) && ic != '0);
            n_pending   = '0;
            if (({1'b0, ic} + WCFG_W'(1)) >= w_eff) begin
                n_in_col = '0;
                if (({1'b0, ir} + HCFG_W'(1)) >= h_eff) begin
                    n_in_row  = '0;
                    n_pending = w_plus1;
                end else begin
                    n_in_row = ir + ROW_W'(1);
                end
            end else begin
                n_in_col = ic + COL_W'(1);
                n_in_row = ir;
            end
        end else begin
            req.valid = accept && drain_ok;
            req.addr  = (drain_d < w_eff) ? drain_d[COL_W-1:0] : '0;
            n_pending = drain_ok ? r_pending - WCFG_W'(1) : '0;
        end
    end

    // Configuration and input-side control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= WIDTH_RESET;
            r_height_cfg <= HEIGHT_RESET;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_pending    <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_addr == REG_FRAME_WIDTH) begin
                r_width_cfg <= i_cfg_data[WCFG_W-1:0];
            end else begin
                r_height_cfg <= i_cfg_data;
            end
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_pending <= '0;
        end else if (accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_pending <= n_pending;
        end
    end

    bbn_line_store u_store (
        .i_clk       (i_clk),
        .i_rd_en     (req.valid),
        .i_rd_addr   (req.addr),
        .i_wr        (wr),
        .o_rd_older  (rd_older),
        .o_rd_recent (rd_recent)
    );

    bbn_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_move      (move),
        .i_restart   (restart),
        .i_width     (w_eff),
        .i_height    (h_eff),
        .i_req       (req),
        .i_rd_older  (rd_older),
        .i_rd_recent (rd_recent),
        .o_wr        (wr),
        .o_mean      (mean)
    );

    bbn_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (move),
        .i_mean  (mean),
        .o_valid (m_tvalid),
        .o_pixel (m_tdata),
        .o_last  (m_tlast)
    );

endmodule
`default_nettype wire
